// ----- src/i2cmts_pkg.sv -----
`timescale 1ns / 1ps
package i2cmts_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int BUF_AW = $clog2(BUFFER_DEPTH);

  localparam logic [7:0] RETRY_BUDGET_RESET = 8'd20;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_EVENT  = 2'd2;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_START     = 3'd1;
  localparam logic [2:0] PH_REP_START = 3'd2;
  localparam logic [2:0] PH_SLAW      = 3'd3;
  localparam logic [2:0] PH_SLAR      = 3'd4;
  localparam logic [2:0] PH_DATA      = 3'd5;
  localparam logic [2:0] PH_REP_DATA  = 3'd6;
  localparam logic [2:0] PH_ERROR     = 3'd7;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_ADDR    = 3'd2;
  localparam logic [2:0] ACT_SEND    = 3'd3;
  localparam logic [2:0] ACT_RX_ACK  = 3'd4;
  localparam logic [2:0] ACT_RX_NACK = 3'd5;
  localparam logic [2:0] ACT_STOP    = 3'd6;

  localparam logic [7:0] STATUS_MASK  = 8'b1111_1000;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_REP_START = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_TX_ACK    = 8'h28;
  localparam logic [7:0] ST_TX_NACK   = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] address_byte;
    logic       is_read;
    logic [5:0] length;
    logic [4:0] byte_index;
    logic [7:0] write_byte;
    logic [7:0] status_code;
    logic [7:0] received_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] bus_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic [4:0] read_position;
    logic       finished;
    logic       expired;
  } out_item_t;

endpackage

// ----- src/i2c_master_transaction_sequencer.sv -----
`timescale 1ns / 1ps
// I2C master transaction sequencer. Each accepted item (header load, write
// byte load or bus status event) yields exactly one result, registered in
// the output entry, or in the skid entry while the output is stalled. One
// item is taken in every cycle while in_stall is low: the state update and
// the result are one registered step through the sequencer core, and a
// two-entry output buffer lets input transfers continue while a result
// waits; in_stall rises only when both entries are held by a stalled output.
module i2c_master_transaction_sequencer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cmts_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cmts_pkg::out_item_t out_data
);

  i2cmts_pkg::out_item_t res;
  i2cmts_pkg::out_item_t out_data_r, skid_data_r;
  logic out_valid_r, skid_valid_r;
  logic in_fire, out_free;

  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  i2cmts_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item_fire  (in_fire),
    .item       (in_data),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_fire) begin
        out_data_r <= res;
      end
    end else if (in_fire) begin
      skid_data_r <= res;
    end
  end

endmodule

// ----- src/i2cmts_core.sv -----
`timescale 1ns / 1ps
module i2cmts_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 item_fire,
  input  i2cmts_pkg::in_item_t item,
  output i2cmts_pkg::out_item_t res
);

  logic [7:0] budget_r;
  logic [2:0] phase_r, phase_nxt;
  logic       active_r, active_nxt;
  logic [7:0] target_r, target_nxt;
  logic       rmode_r, rmode_nxt;
  logic [5:0] total_r, total_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic [7:0] ttl_r, ttl_nxt;
  logic [7:0] tx_buf_r [i2cmts_pkg::BUFFER_DEPTH];

  logic [7:0] s;
  logic [5:0] pos_inc;
  logic [6:0] pos_inc_w;
  logic [5:0] rd_idx;
  logic [7:0] rd_byte;

  assign s         = item.status_code & i2cmts_pkg::STATUS_MASK;
  assign pos_inc   = pos_r + 6'd1;
  assign pos_inc_w = {1'b0, pos_r} + 7'd1;

  always_comb begin
    if (phase_r == i2cmts_pkg::PH_SLAW) begin
      rd_idx = '0;
    end else if (s == i2cmts_pkg::ST_TX_NACK) begin
      rd_idx = (pos_r != '0) ? pos_r - 6'd1 : '0;
    end else begin
      rd_idx = pos_r;
    end
  end

  assign rd_byte = (32'(rd_idx) < i2cmts_pkg::BUFFER_DEPTH) ?
                   tx_buf_r[rd_idx[i2cmts_pkg::BUF_AW-1:0]] : 8'd0;

  always_comb begin
    phase_nxt  = phase_r;
    active_nxt = active_r;
    target_nxt = target_r;
    rmode_nxt  = rmode_r;
    total_nxt  = total_r;
    pos_nxt    = pos_r;
    ttl_nxt    = ttl_r;
    res        = '0;

    if (item.kind == i2cmts_pkg::KIND_HEADER) begin
      target_nxt = item.address_byte;
      rmode_nxt  = item.is_read;
      total_nxt  = (32'(item.length) > i2cmts_pkg::BUFFER_DEPTH) ?
                   6'(i2cmts_pkg::BUFFER_DEPTH) : item.length;
      pos_nxt    = '0;
      ttl_nxt    = budget_r;
      phase_nxt  = i2cmts_pkg::PH_IDLE;
      active_nxt = 1'b1;
    end else if (item.kind == i2cmts_pkg::KIND_EVENT && active_r) begin
      if (ttl_r == '0) begin
        res.action   = i2cmts_pkg::ACT_STOP;
        res.finished = 1'b1;
        res.expired  = 1'b1;
        active_nxt   = 1'b0;
        phase_nxt    = i2cmts_pkg::PH_IDLE;
      end else begin
        unique case (phase_r) inside
          i2cmts_pkg::PH_IDLE: begin
            phase_nxt  = i2cmts_pkg::PH_START;
            res.action = i2cmts_pkg::ACT_START;
          end
          i2cmts_pkg::PH_START, i2cmts_pkg::PH_REP_START: begin
            if (s == i2cmts_pkg::ST_START || s == i2cmts_pkg::ST_REP_START) begin
              res.action = i2cmts_pkg::ACT_ADDR;
              if (rmode_r) begin
                phase_nxt    = i2cmts_pkg::PH_SLAR;
                res.bus_byte = target_r | 8'h01;
              end else begin
                phase_nxt    = i2cmts_pkg::PH_SLAW;
                res.bus_byte = target_r & 8'hFE;
              end
            end else begin
              phase_nxt = i2cmts_pkg::PH_ERROR;
            end
            if (phase_r == i2cmts_pkg::PH_REP_START) begin
              ttl_nxt = ttl_r - 8'd1;
            end
          end
          i2cmts_pkg::PH_SLAW: begin
            case (s)
              i2cmts_pkg::ST_SLAW_ACK: begin
                if (total_r != '0) begin
                  phase_nxt    = i2cmts_pkg::PH_DATA;
                  ttl_nxt      = budget_r;
                  res.action   = i2cmts_pkg::ACT_SEND;
                  res.bus_byte = rd_byte;
                  pos_nxt      = pos_inc;
                end else begin
                  res.action   = i2cmts_pkg::ACT_STOP;
                  res.finished = 1'b1;
                  active_nxt   = 1'b0;
                  phase_nxt    = i2cmts_pkg::PH_IDLE;
                end
              end
              i2cmts_pkg::ST_SLAW_NACK: begin
                phase_nxt  = i2cmts_pkg::PH_REP_START;
                res.action = i2cmts_pkg::ACT_START;
              end
              default: phase_nxt = i2cmts_pkg::PH_ERROR;
            endcase
          end
          i2cmts_pkg::PH_SLAR: begin
            case (s)
              i2cmts_pkg::ST_SLAR_ACK: begin
                if (total_r != '0) begin
                  phase_nxt  = i2cmts_pkg::PH_DATA;
                  ttl_nxt    = budget_r;
                  res.action = (total_r > 6'd1) ? i2cmts_pkg::ACT_RX_ACK :
                                                  i2cmts_pkg::ACT_RX_NACK;
                end else begin
                  res.action   = i2cmts_pkg::ACT_STOP;
                  res.finished = 1'b1;
                  active_nxt   = 1'b0;
                  phase_nxt    = i2cmts_pkg::PH_IDLE;
                end
              end
              i2cmts_pkg::ST_SLAR_NACK: begin
                phase_nxt  = i2cmts_pkg::PH_REP_START;
                res.action = i2cmts_pkg::ACT_START;
              end
              default: phase_nxt = i2cmts_pkg::PH_ERROR;
            endcase
          end
          i2cmts_pkg::PH_DATA, i2cmts_pkg::PH_REP_DATA: begin
            case (s)
              i2cmts_pkg::ST_TX_ACK: begin
                if (pos_r >= total_r) begin
                  res.action   = i2cmts_pkg::ACT_STOP;
                  res.finished = 1'b1;
                  active_nxt   = 1'b0;
                  phase_nxt    = i2cmts_pkg::PH_IDLE;
                end else begin
                  res.action   = i2cmts_pkg::ACT_SEND;
                  res.bus_byte = rd_byte;
                  pos_nxt      = pos_inc;
                end
              end
              i2cmts_pkg::ST_TX_NACK: begin
                phase_nxt    = i2cmts_pkg::PH_REP_DATA;
                res.action   = i2cmts_pkg::ACT_SEND;
                res.bus_byte = rd_byte;
              end
              i2cmts_pkg::ST_RX_ACK: begin
                res.read_valid    = 1'b1;
                res.read_data     = item.received_byte;
                res.read_position = pos_r[4:0];
                res.action        = (pos_inc_w >= {1'b0, total_r}) ?
                                    i2cmts_pkg::ACT_RX_NACK : i2cmts_pkg::ACT_RX_ACK;
                pos_nxt           = pos_inc;
              end
              i2cmts_pkg::ST_RX_NACK: begin
                res.read_valid    = 1'b1;
                res.read_data     = item.received_byte;
                res.read_position = pos_r[4:0];
                pos_nxt           = pos_inc;
                res.action        = i2cmts_pkg::ACT_STOP;
                res.finished      = 1'b1;
                active_nxt        = 1'b0;
                phase_nxt         = i2cmts_pkg::PH_IDLE;
              end
              default: phase_nxt = i2cmts_pkg::PH_ERROR;
            endcase
            if (phase_r == i2cmts_pkg::PH_REP_DATA && active_nxt) begin
              ttl_nxt = ttl_r - 8'd1;
            end
          end
          default: ttl_nxt = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= i2cmts_pkg::RETRY_BUDGET_RESET;
      phase_r  <= i2cmts_pkg::PH_IDLE;
      active_r <= 1'b0;
      target_r <= '0;
      rmode_r  <= 1'b0;
      total_r  <= '0;
      pos_r    <= '0;
      ttl_r    <= i2cmts_pkg::RETRY_BUDGET_RESET;
    end else begin
      if (cfg_wr_en) begin
        budget_r <= cfg_wr_data;
      end
      if (item_fire) begin
        phase_r  <= phase_nxt;
        active_r <= active_nxt;
        target_r <= target_nxt;
        rmode_r  <= rmode_nxt;
        total_r  <= total_nxt;
        pos_r    <= pos_nxt;
        ttl_r    <= ttl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && item.kind == i2cmts_pkg::KIND_WRITE &&
        32'(item.byte_index) < i2cmts_pkg::BUFFER_DEPTH) begin
      tx_buf_r[item.byte_index[i2cmts_pkg::BUF_AW-1:0]] <= item.write_byte;
    end
  end

endmodule
